// File: design/ttu_pkg.sv
// ttu_pkg: shared types and constants of the text-to-unsigned parser.
// No dependencies; imported by ttu_front, ttu_back and the top level.
`timescale 1ns / 1ps

package ttu_pkg;

  // Width of the consumed byte count, saturating at its all-ones value.
  localparam int unsigned COUNT_WIDTH = 12;

  localparam int unsigned BASE_WIDTH  = 6;
  localparam int unsigned VALUE_WIDTH = 64;

  // Character codes used by the classifier.
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_LC_X  = 8'h78;
  localparam logic [7:0] CHAR_UC_X  = 8'h58;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;

  // Radix codes.
  localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_WIDTH-1:0] BASE_RESET = BASE_DEC;

  // One classified input byte, as handed from the front to the back.
  typedef struct packed {
    logic                  start;   // first byte of a new string
    logic                  blank;   // space or tab
    logic                  plus;    // '+'
    logic                  zero;    // '0'
    logic                  is_x;    // 'x' or 'X'
    logic                  dig_ok;  // alphanumeric digit
    logic [BASE_WIDTH-1:0] dig;     // digit value 0..35
  } byte_class_t;

endpackage

// File: design/text_to_unsigned_parser_unit.sv
// text_to_unsigned_parser_unit: top level of the streaming ASCII-to-unsigned
// parser. Depends on ttu_pkg, ttu_front and ttu_back.
//
// Usage:
//   Input channel (push/full): one byte per transaction, character_i with
//   string_start_i marking the first byte of a string. A transaction is
//   taken at a clock edge with push high and full low.
//   Result channel (empty/pop): while empty is low, value_o and
//   consumed_count_o show the oldest result; pop high at an edge takes it.
//   At most one result per string, from the first byte that is not a digit
//   of the radix (NUL included); later bytes are dropped until a new start.
//   Config channel (cfg_valid_i/cfg_ready_o): writes the radix, 0 = detect
//   from the prefix. Ready is always high; write only while idle.
// Timing:
//   The back end parses a byte as it takes it from the byte queue; a result
//   waits in the result queue. Throughput is one byte per cycle unless
//   stalled, set by the single 64 x 6 multiply-add on the accumulator.
// Reset: both queues empty, parser waiting for a start, radix 10.
// Stall: a held-off result fills the two-entry result queue, then the back
//   end stops taking bytes, the two-entry byte queue fills and full rises.
`timescale 1ns / 1ps

module text_to_unsigned_parser_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [7:0]                         character_i,
  input  logic                               string_start_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [ttu_pkg::VALUE_WIDTH-1:0]    value_o,
  output logic [ttu_pkg::COUNT_WIDTH-1:0]    consumed_count_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ttu_pkg::BASE_WIDTH-1:0]     cfg_base_setting_i
);
  import ttu_pkg::*;

  logic [BASE_WIDTH-1:0] base_setting_q;
  logic                  fb_valid;
  logic                  fb_take;
  byte_class_t           fb_item;

  // Radix register; written by a config transaction.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_setting_q <= BASE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_setting_q <= cfg_base_setting_i;
    end
  end

  // Front end: byte classification and the byte queue.
  ttu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .character_i    (character_i),
    .string_start_i (string_start_i),
    .out_valid_o    (fb_valid),
    .out_item_o     (fb_item),
    .out_take_i     (fb_take)
  );

  // Back end: parse sequencer, accumulator and result queue.
  ttu_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (fb_valid),
    .in_item_i        (fb_item),
    .in_take_o        (fb_take),
    .base_setting_i   (base_setting_q),
    .pop_i            (pop),
    .empty_o          (empty),
    .value_o          (value_o),
    .consumed_count_o (consumed_count_o)
  );

endmodule

// File: design/ttu_front.sv
// ttu_front: classifies incoming bytes and holds them in a two-entry queue.
// Depends on ttu_pkg.
`timescale 1ns / 1ps

module ttu_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [7:0]            character_i,
  input  logic                  string_start_i,
  output logic                  out_valid_o,
  output ttu_pkg::byte_class_t  out_item_o,
  input  logic                  out_take_i
);
  import ttu_pkg::*;

  byte_class_t cls;
  byte_class_t q_mem [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_push, do_pop;

  always_comb begin
    cls        = '0;
    cls.start  = string_start_i;
    cls.blank  = (character_i == CHAR_SPACE) || (character_i == CHAR_TAB);
    cls.plus   = (character_i == CHAR_PLUS);
    cls.zero   = (character_i == CHAR_ZERO);
    cls.is_x   = (character_i == CHAR_LC_X) || (character_i == CHAR_UC_X);
    if (character_i >= CHAR_ZERO && character_i <= CHAR_NINE) begin
      cls.dig_ok = 1'b1;
      cls.dig    = BASE_WIDTH'(character_i - CHAR_ZERO);
    end else if (character_i >= CHAR_UC_A && character_i <= CHAR_UC_Z) begin
      cls.dig_ok = 1'b1;
      cls.dig    = BASE_WIDTH'(character_i - CHAR_UC_A + 8'd10);
    end else if (character_i >= CHAR_LC_A && character_i <= CHAR_LC_Z) begin
      cls.dig_ok = 1'b1;
      cls.dig    = BASE_WIDTH'(character_i - CHAR_LC_A + 8'd10);
    end
  end

  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = q_mem[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = out_take_i && out_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("front queue count out of range");

endmodule

// File: design/ttu_back.sv
// ttu_back: parse sequencer with the accumulator multiply-add and the
// two-entry result queue. Depends on ttu_pkg.
`timescale 1ns / 1ps

module ttu_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  ttu_pkg::byte_class_t               in_item_i,
  output logic                               in_take_o,
  input  logic [ttu_pkg::BASE_WIDTH-1:0]     base_setting_i,
  input  logic                               pop_i,
  output logic                               empty_o,
  output logic [ttu_pkg::VALUE_WIDTH-1:0]    value_o,
  output logic [ttu_pkg::COUNT_WIDTH-1:0]    consumed_count_o
);
  import ttu_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_BLANKS    = 6'b000010,
    ST_PREFIX    = 6'b000100,
    ST_ZERO_AUTO = 6'b001000,
    ST_ZERO_HEX  = 6'b010000,
    ST_DIGITS    = 6'b100000
  } state_e;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [COUNT_WIDTH-1:0] count;
  } result_t;

  state_e                   state_q, st_v, ph;
  logic [VALUE_WIDTH-1:0]   acc_q, acc_base, acc_n;
  logic [VALUE_WIDTH+BASE_WIDTH-1:0] prod;
  logic [BASE_WIDTH-1:0]    eb_q, eb_v;
  logic [COUNT_WIDTH-1:0]   cnt_q, cnt_base, cnt_n;
  logic [COUNT_WIDTH:0]     cnt_sum;
  logic [1:0]               inc_v, inc_tot;
  logic                     to_pre, to_dig, dig_hit, emit;
  logic                     take;

  result_t                  res_mem [2];
  logic                     res_wr_q, res_rd_q;
  logic [1:0]               res_cnt_q;
  logic                     res_push, res_pop;

  assign in_take_o = in_valid_i && (res_cnt_q != 2'd2);
  assign take      = in_take_o;

  // One byte per cycle unless stalled: the start flag zeroes the working
  // state, then the phase logic decides: skip, set a radix, digit or stop.
  always_comb begin
    ph       = in_item_i.start ? ST_BLANKS : state_q;
    acc_base = in_item_i.start ? '0 : acc_q;
    eb_v     = in_item_i.start ? '0 : eb_q;
    cnt_base = in_item_i.start ? '0 : cnt_q;
    st_v     = ph;
    inc_v    = 2'd0;
    to_pre   = 1'b0;
    to_dig   = 1'b0;
    unique case (ph)
      ST_IDLE: begin
        st_v = ST_IDLE;
      end
      ST_BLANKS: begin
        if (in_item_i.blank) begin
          inc_v = 2'd1;
        end else if (in_item_i.plus) begin
          inc_v = 2'd1;
          st_v  = ST_PREFIX;
        end else begin
          to_pre = 1'b1;
        end
      end
      ST_PREFIX: begin
        to_pre = 1'b1;
      end
      ST_ZERO_AUTO: begin
        if (in_item_i.is_x) begin
          eb_v  = BASE_HEX;
          inc_v = 2'd1;
          st_v  = ST_DIGITS;
        end else begin
          eb_v   = BASE_OCT;
          to_dig = 1'b1;
        end
      end
      ST_ZERO_HEX: begin
        if (in_item_i.is_x) begin
          inc_v = 2'd2;
          st_v  = ST_DIGITS;
        end else begin
          // the held zero counts as a digit of value zero
          inc_v  = 2'd1;
          to_dig = 1'b1;
        end
      end
      ST_DIGITS: begin
        to_dig = 1'b1;
      end
      default: begin
        st_v = ST_IDLE;
      end
    endcase

    if (to_pre) begin
      if (base_setting_i == BASE_AUTO) begin
        if (in_item_i.zero) begin
          inc_v = 2'd1;
          st_v  = ST_ZERO_AUTO;
        end else begin
          eb_v   = BASE_DEC;
          to_dig = 1'b1;
        end
      end else if (base_setting_i == BASE_HEX) begin
        eb_v = BASE_HEX;
        if (in_item_i.zero) begin
          st_v = ST_ZERO_HEX;
        end else begin
          to_dig = 1'b1;
        end
      end else begin
        eb_v   = base_setting_i;
        to_dig = 1'b1;
      end
    end

    dig_hit = to_dig && in_item_i.dig_ok && (in_item_i.dig < eb_v);
    emit    = to_dig && !dig_hit;
    if (to_dig) begin
      st_v = dig_hit ? ST_DIGITS : ST_IDLE;
    end
  end

  // Multiply-add, wrapping at 64 bits; a 64 x 6 product.
  always_comb begin
    prod  = acc_base * eb_v;
    acc_n = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(in_item_i.dig);
  end

  // Saturating count; the increment never exceeds two.
  always_comb begin
    inc_tot = inc_v + 2'(dig_hit);
    cnt_sum = {1'b0, cnt_base} + (COUNT_WIDTH+1)'(inc_tot);
    cnt_n   = cnt_sum[COUNT_WIDTH] ? '1 : cnt_sum[COUNT_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= '0;
      eb_q    <= '0;
      cnt_q   <= '0;
    end else if (take) begin
      state_q <= st_v;
      acc_q   <= dig_hit ? acc_n : acc_base;
      eb_q    <= eb_v;
      cnt_q   <= cnt_n;
    end
  end

  // Result queue.
  assign res_push         = take && emit;
  assign res_pop          = pop_i && (res_cnt_q != 2'd0);
  assign empty_o          = (res_cnt_q == 2'd0);
  assign value_o          = res_mem[res_rd_q].value;
  assign consumed_count_o = res_mem[res_rd_q].count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr_q <= !res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= !res_rd_q;
      end
      res_cnt_q <= res_cnt_q + 2'(res_push) - 2'(res_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem[res_wr_q] <= '{value: acc_base, count: cnt_n};
    end
  end

  a_emit_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |=> (state_q == ST_IDLE))
    else $error("parser not idle after a result");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && (state_q == ST_IDLE) && !in_item_i.start)
      |=> ($stable(acc_q) && (state_q == ST_IDLE)))
    else $error("idle parser changed state on an ignored byte");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !in_item_i.start) |=> (cnt_q >= $past(cnt_q)))
    else $error("byte count decreased within a string");

endmodule

// File: tb/sv/ttu_sb_pkg.sv
// ttu_sb_pkg: scoreboard for the text-to-unsigned parser testbench.
// Holds the byte-level predictor and the queue of awaited parse results.
// Depends on ttu_pkg (widths, radix codes, character codes).
`timescale 1ns / 1ps

package ttu_sb_pkg;
  import ttu_pkg::*;

  typedef enum logic [2:0] {
    SCAN_OFF,
    SCAN_LEAD,
    SCAN_RADIX,
    SCAN_AUTO_ZERO,
    SCAN_HEX_ZERO,
    SCAN_DIGITS
  } scan_state_e;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [COUNT_WIDTH-1:0] count;
  } parse_result_t;

  localparam int unsigned NOT_A_DIGIT = 255;
  localparam int unsigned COUNT_MAX   = (1 << COUNT_WIDTH) - 1;

  class ttu_scoreboard;
    logic [BASE_WIDTH-1:0]  base_reg;
    scan_state_e            state;
    logic [VALUE_WIDTH-1:0] acc;
    logic [BASE_WIDTH-1:0]  radix;
    logic [COUNT_WIDTH-1:0] consumed;
    parse_result_t          awaited[$];
    int unsigned            errors;

    function new();
      base_reg = BASE_RESET;
      state    = SCAN_OFF;
      acc      = '0;
      radix    = '0;
      consumed = '0;
      errors   = 0;
    endfunction

    function void write_base(logic [BASE_WIDTH-1:0] b);
      base_reg = b;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // saturating byte counter
    function void bump(int unsigned n);
      int unsigned t;
      t = consumed + n;
      if (t > COUNT_MAX) t = COUNT_MAX;
      consumed = t[COUNT_WIDTH-1:0];
    endfunction

    function int unsigned digit_value(logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) return c - CHAR_ZERO;
      if (c >= CHAR_UC_A && c <= CHAR_UC_Z) return c - CHAR_UC_A + 10;
      if (c >= CHAR_LC_A && c <= CHAR_LC_Z) return c - CHAR_LC_A + 10;
      return NOT_A_DIGIT;
    endfunction

    // Advance the predicted parse by one accepted byte. Returns 1 when the
    // byte took part in a parse, 0 when it was dropped.
    function bit note_byte(logic [7:0] c, logic s);
      int unsigned d;
      bit          c_is_x;
      c_is_x = (c == CHAR_LC_X) || (c == CHAR_UC_X);
      if (s) begin
        state    = SCAN_LEAD;
        acc      = '0;
        radix    = '0;
        consumed = '0;
      end
      if (state == SCAN_OFF) return 1'b0;

      if (state == SCAN_LEAD) begin
        if (c == CHAR_SPACE || c == CHAR_TAB) begin
          bump(1);
          return 1'b1;
        end
        state = SCAN_RADIX;
        if (c == CHAR_PLUS) begin
          bump(1);
          return 1'b1;
        end
      end

      if (state == SCAN_RADIX) begin
        if (base_reg == BASE_AUTO) begin
          if (c == CHAR_ZERO) begin
            bump(1);
            state = SCAN_AUTO_ZERO;
            return 1'b1;
          end
          radix = BASE_DEC;
        end else if (base_reg == BASE_HEX) begin
          radix = BASE_HEX;
          if (c == CHAR_ZERO) begin
            state = SCAN_HEX_ZERO;
            return 1'b1;
          end
        end else begin
          radix = base_reg;
        end
        state = SCAN_DIGITS;
      end else if (state == SCAN_AUTO_ZERO) begin
        state = SCAN_DIGITS;
        if (c_is_x) begin
          radix = BASE_HEX;
          bump(1);
          return 1'b1;
        end
        radix = BASE_OCT;
      end else if (state == SCAN_HEX_ZERO) begin
        state = SCAN_DIGITS;
        if (c_is_x) begin
          bump(2);
          return 1'b1;
        end
        // held zero turns out to be a plain digit
        acc = '0;
        bump(1);
      end

      d = digit_value(c);
      if (d < radix) begin
        acc = acc * VALUE_WIDTH'(radix) + VALUE_WIDTH'(d);
        bump(1);
        return 1'b1;
      end
      awaited.push_back('{value: acc, count: consumed});
      state = SCAN_OFF;
      return 1'b1;
    endfunction

    function void check_result(logic [VALUE_WIDTH-1:0] v, logic [COUNT_WIDTH-1:0] n);
      parse_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result: value %h count %0d", $time, v, n);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (v !== want.value) begin
        $display("%0t: value mismatch: expected %h actual %h", $time, want.value, v);
        errors++;
      end
      if (n !== want.count) begin
        $display("%0t: consumed_count mismatch: expected %0d actual %0d",
                 $time, want.count, n);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: tb/sv/text_to_unsigned_parser_unit_tb.sv
// text_to_unsigned_parser_unit_tb: self-checking testbench of the parser.
// Directed strings, then random strings under several radix settings and
// idle mixes. Depends on ttu_pkg, ttu_sb_pkg and the parser RTL.
`timescale 1ns / 1ps

module text_to_unsigned_parser_unit_tb;
  import ttu_pkg::*;
  import ttu_sb_pkg::*;

  localparam logic [7:0] NUL_CHAR      = 8'h00;
  localparam int         SETTLE_CYCLES = 10;     // covers byte queue + parse stage
  localparam int         HOLD_CYCLES   = 400;    // long receiver hold-off
  localparam int         SEG_ITEMS     = 82;     // bytes sent per random segment
  localparam int         WRAP_DIGITS   = 40;     // enough digits to wrap the value
  localparam longint     TIMEOUT_NS    = 4_000_000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   push;
  logic                   full;
  logic [7:0]             character_i;
  logic                   string_start_i;
  logic                   empty;
  logic                   pop;
  logic [VALUE_WIDTH-1:0] value_o;
  logic [COUNT_WIDTH-1:0] consumed_count_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [BASE_WIDTH-1:0]  cfg_base_setting_i;

  ttu_scoreboard          sb;
  int                     tx_idle_pct;
  int                     rx_idle_pct;
  bit                     hold_req;
  bit                     lead_byte;      // next put() opens a new string
  int                     sent_items;
  logic [BASE_WIDTH-1:0]  cur_base;

  text_to_unsigned_parser_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .character_i        (character_i),
    .string_start_i     (string_start_i),
    .empty              (empty),
    .pop                (pop),
    .value_o            (value_o),
    .consumed_count_o   (consumed_count_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_base_setting_i (cfg_base_setting_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one byte from the next falling edge, with random idle cycles in
  // front, and hold it until a rising edge sees full low. Push stays high on
  // return so back-to-back transactions need no gap.
  task automatic send_byte(input logic [7:0] c, input logic s);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push           <= 1'b1;
    character_i    <= c;
    string_start_i <= s;
    do @(posedge clk_i); while (full);
    void'(sb.note_byte(c, s));
    sent_items++;
  endtask

  // Next byte of the current string; the first one carries the start flag.
  task automatic put(input logic [7:0] c);
    send_byte(c, lead_byte);
    lead_byte = 1'b0;
  endtask

  // Sender pause: drop push, wait for every awaited result, then let the
  // last bytes (which may cause no result) drain through the pipeline.
  task automatic wait_idle();
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Radix register write, only issued once the block has gone quiet.
  task automatic write_radix(input logic [BASE_WIDTH-1:0] b);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i        <= 1'b1;
    cfg_base_setting_i <= b;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_base(b);
    cur_base = b;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] digit_char(input int unsigned v);
    if (v < 10) return CHAR_ZERO + 8'(v);
    return ($urandom_range(1) ? CHAR_LC_A : CHAR_UC_A) + 8'(v - 10);
  endfunction

  // Radix mix: the special codes, the usual radixes, the edges, and noise.
  function automatic logic [BASE_WIDTH-1:0] pick_base();
    case ($urandom_range(7))
      0: return BASE_AUTO;
      1: return BASE_HEX;
      2: return BASE_DEC;
      3: return BASE_OCT;
      4: return BASE_WIDTH'(2);
      5: return BASE_WIDTH'(36);
      6: return BASE_WIDTH'(1);
      default: return BASE_WIDTH'($urandom_range(63));
    endcase
  endfunction

  // One random string. Mostly well formed (blanks, sign, prefix, digits of
  // the radix in use, a stop byte, ignored tail); some left unfinished so
  // the next start abandons them; some pure noise with random start flags.
  task automatic gen_string();
    int r;
    int n;
    int k;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(6, 1);
      repeat (n) send_byte(8'($urandom_range(255)), ($urandom_range(3) == 0));
      return;
    end
    lead_byte = 1'b1;
    repeat ($urandom_range(2)) put($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
    if ($urandom_range(9) < 3) put(CHAR_PLUS);
    r = (cur_base > 36) ? 36 : int'(cur_base);
    if (cur_base == BASE_AUTO) begin
      // 0 -> hex prefix, 1 -> octal zero, 2 -> plain decimal
      k = $urandom_range(2);
      r = (k == 0) ? 16 : (k == 1) ? 8 : 10;
      if (k != 2) put(CHAR_ZERO);
      if (k == 0) put($urandom_range(1) ? CHAR_LC_X : CHAR_UC_X);
    end else if (cur_base == BASE_HEX && $urandom_range(1)) begin
      put(CHAR_ZERO);
      put($urandom_range(1) ? CHAR_LC_X : CHAR_UC_X);
    end
    // long runs can overflow the 64-bit accumulator
    n = ($urandom_range(4) == 0) ? $urandom_range(24, 9) : $urandom_range(8);
    repeat (n) put(digit_char($urandom_range(r - 1)));
    k = $urandom_range(9);
    if (k < 4) begin
      put(NUL_CHAR);
    end else if (k < 7) begin
      put(8'($urandom_range(255)));
    end else if (k < 8) begin
      // alphanumeric but not below the radix, or punctuation at radix 36
      put((r < 36) ? digit_char($urandom_range(35, r)) : 8'($urandom_range(8'h2F, 8'h21)));
    end
    if ($urandom_range(9) < 3) repeat ($urandom_range(3, 1)) put(8'($urandom_range(255)));
  endtask

  // Result side: pops at random, or holds off for HOLD_CYCLES when asked.
  initial begin : receiver
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clk_i);
        hold_req = 1'b0;
      end
      pop <= ($urandom_range(99) >= rx_idle_pct);
      @(posedge clk_i);
      if (pop && !empty) sb.check_result(value_o, consumed_count_o);
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    sb                 = new();
    rst_ni             = 1'b0;
    push               = 1'b0;
    character_i        = NUL_CHAR;
    string_start_i     = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_base_setting_i = BASE_RESET;
    cur_base           = BASE_RESET;
    tx_idle_pct        = 0;
    rx_idle_pct        = 0;
    hold_req           = 1'b0;
    lead_byte          = 1'b0;
    sent_items         = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- directed part, radix 10 out of reset ----
    // byte before any start: dropped
    send_byte("7", 1'b0);
    // blanks, sign, digits, top-code stop byte
    lead_byte = 1'b1;
    put(CHAR_SPACE); put(CHAR_TAB); put(CHAR_PLUS); put("9"); put("9"); put(8'hFF);
    // restart in the middle of a parse: first string gives no result
    lead_byte = 1'b1;
    put("1"); put("2");
    lead_byte = 1'b1;
    put("3"); put(NUL_CHAR);
    // no digits at all: count covers the blank and the sign
    lead_byte = 1'b1;
    put(CHAR_SPACE); put(CHAR_PLUS); put("-");
    // radix write in the middle of a string: the latched radix 10 stays
    lead_byte = 1'b1;
    put("1"); put("2");
    write_radix(BASE_HEX);
    put("a");
    // hex with optional prefix
    lead_byte = 1'b1;
    put(CHAR_ZERO); put(CHAR_UC_X); put("f"); put("F"); put("g");
    // auto detect: bare prefix, then lone zero read as octal
    write_radix(BASE_AUTO);
    lead_byte = 1'b1;
    put(CHAR_ZERO); put(CHAR_LC_X); put(NUL_CHAR);
    lead_byte = 1'b1;
    put(CHAR_ZERO); put("8");
    // top register value: every alphanumeric is a digit
    write_radix(BASE_WIDTH'(63));
    lead_byte = 1'b1;
    put("z"); put(8'h80);

    // ---- one long decimal string: value wraps ----
    write_radix(BASE_DEC);
    lead_byte = 1'b1;
    put("1");
    repeat (WRAP_DIGITS) put(digit_char($urandom_range(9)));
    put(NUL_CHAR);

    // ---- random part: three idle mixes, several radix settings each ----
    sent_items = 0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 17; rx_idle_pct = 82; end
        1: begin tx_idle_pct = 82; rx_idle_pct = 17; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 6; seg++) begin
        write_radix(pick_base());
        // no idling on either side: stall the receiver so both queues fill
        // while the sender keeps offering bytes
        if (ph == 2 && seg == 2) hold_req = 1'b1;
        while (sent_items < (ph * 6 + seg + 1) * SEG_ITEMS) gen_string();
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
